// ===== rtl/core/spq_pkg.sv =====
// Shared constants, types and codes of the sorted priority queue.
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int PRIO_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int ENTRY_W     = 5;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [PRIO_W-1:0]  prio_type;

   typedef struct packed {
      cell_op_type op;
      value_type   new_value;
      prio_type    new_prio;
   } cell_ctrl_type;

   typedef struct packed {
      value_type value;
      prio_type  prio;
   } slot_type;

endpackage

// ===== rtl/core/spq_if.sv =====
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if import spq_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      command;
   value_type item_value;
   prio_type  item_priority;

   modport source (output valid, command, item_value, item_priority, input ready);
   modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   value_type           popped_value;
   prio_type            popped_priority;
   logic [ENTRY_W-1:0]  entry_count;

   modport source (output valid, status, popped_value, popped_priority, entry_count,
                   input ready);
   modport sink   (input valid, status, popped_value, popped_priority, entry_count,
                   output ready);
endinterface

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain: holds a pair and shifts it left or right.
module spq_cell import spq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          left_greater,
   input  slot_type      left_slot,
   input  slot_type      right_slot,
   output logic          greater,
   output slot_type      slot
);

   slot_type slot_ff, slot_in;

   assign greater = occupied && (slot_ff.prio > ctrl.new_prio);
   assign slot    = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (left_greater) begin
               slot_in = left_slot;
            end else if (greater || !occupied) begin
               slot_in.value = ctrl.new_value;
               slot_in.prio  = ctrl.new_prio;
            end
         end
         CELL_REMOVE: slot_in = right_slot;
         default:     slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, count and response register.
// Usage:
// Requests arrive on req_channel. A request with command insert places the
// pair (item_value, item_priority) behind every stored pair of equal or
// smaller priority; a request with command remove pops the most urgent pair.
// Every request produces exactly one response on rsp_channel with a status
// (done, full or empty), the popped pair (zero unless a remove succeeded)
// and the count of stored pairs after the request.
// The response appears in the cycle after the request is taken, from an output
// register. A new request can be taken in every cycle while no response is
// pending or the pending one is taken: the chain of cells compares all slots
// with the new priority at once and shifts, so throughput is one request per cycle.
// If the receiver holds rsp_channel.ready low, the response stays in the
// output register and req_channel.ready stays low until it is taken.
// Reset empties the queue and drops any pending response; slot contents are
// not cleared, since only slots below the count are ever read.
module sorted_priority_queue import spq_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   spq_req_if.sink   req_channel,
   spq_rsp_if.source rsp_channel
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   slot_type           popped_ff, popped_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;

   logic          accept;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;

   slot_type cell_slot    [QUEUE_DEPTH];
   logic     cell_greater [QUEUE_DEPTH];

   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;
   assign accept = req_channel.valid && req_channel.ready;
   assign full   = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      ctrl.op        = CELL_HOLD;
      ctrl.new_value = req_channel.item_value;
      ctrl.new_prio  = req_channel.item_priority;
      count_in       = count_ff;
      status_in      = ST_DONE;
      popped_in      = '0;
      if (req_channel.command == CMD_INSERT) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            ctrl.op  = accept ? CELL_INSERT : CELL_HOLD;
            count_in = accept ? count_ff + COUNT_W'(1) : count_ff;
         end
      end else begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            ctrl.op   = accept ? CELL_REMOVE : CELL_HOLD;
            count_in  = accept ? count_ff - COUNT_W'(1) : count_ff;
            popped_in = cell_slot[0];
         end
      end
      entry_in = ENTRY_W'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic     left_greater;
      slot_type left_slot;
      slot_type right_slot;

      if (i == 0) begin : g_head
         assign left_greater = 1'b0;
         assign left_slot    = cell_slot[i];
      end else begin : g_body
         assign left_greater = cell_greater[i-1];
         assign left_slot    = cell_slot[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_slot = cell_slot[i];
      end else begin : g_inner
         assign right_slot = cell_slot[i+1];
      end

      spq_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .occupied     (COUNT_W'(i) < count_ff),
         .left_greater (left_greater),
         .left_slot    (left_slot),
         .right_slot   (right_slot),
         .greater      (cell_greater[i]),
         .slot         (cell_slot[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         popped_ff <= popped_in;
         entry_ff  <= entry_in;
      end
   end

   assign rsp_channel.valid           = rsp_valid_ff;
   assign rsp_channel.status          = status_ff;
   assign rsp_channel.popped_value    = popped_ff.value;
   assign rsp_channel.popped_priority = popped_ff.prio;
   assign rsp_channel.entry_count     = entry_ff;

endmodule

// ===== rtl/core/spq_checker.sv =====
// Port-level checks of the sorted priority queue and their binding.
module spq_checker import spq_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input value_type           rsp_popped_value,
   input prio_type            rsp_popped_priority,
   input logic [ENTRY_W-1:0]  rsp_entry_count
);

   // A dropped insert can only happen with every slot taken.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_entry_count == ENTRY_W'(QUEUE_DEPTH))
      else $error("full status with count below depth");

   // A failed remove leaves the queue empty.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_entry_count == '0)
      else $error("empty status with nonzero count");

   // Only a successful remove returns a pair.
   a_no_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |->
         (rsp_popped_value == '0) && (rsp_popped_priority == '0))
      else $error("popped pair on failed request");

   // Reset drops any pending response.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count))
      else $error("stalled response changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_channel.valid),
   .rsp_ready           (rsp_channel.ready),
   .rsp_status          (rsp_channel.status),
   .rsp_popped_value    (rsp_channel.popped_value),
   .rsp_popped_priority (rsp_channel.popped_priority),
   .rsp_entry_count     (rsp_channel.entry_count)
);
